>>> sv/btb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_pkg
// Shared constants and types for the branch target buffer: table size,
// field widths, stream packing and the controller/datapath interface.
// ----------------------------------------------------------------------------
package btb_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths
    localparam int ADDR_W = 32;
    localparam int CTR_W  = 2;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_BITS   = ADDR_W + 1 + ADDR_W + 1;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 1 + ADDR_W + 1 + ADDR_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command codes carried in tuser
    localparam logic CMD_LOOKUP  = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // Counter thresholds
    localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;
    localparam logic [CTR_W-1:0] CTR_TAKEN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the input transaction
        logic search;   // compare all tags, register hit and free vectors
        logic apply;    // update table and load the output register
        logic drain;    // output transaction taken downstream
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_valid;
    } t_dp_status;

endpackage

>>> sv/btb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_ctrl
// Sequencer for the branch target buffer: capture, search, apply.
// ----------------------------------------------------------------------------
module btb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_m_tready,
    input  btb_pkg::t_dp_status i_status,
    output logic                o_s_tready,
    output btb_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY
    } t_state;

    t_state r_state;
    logic   r_s_ready;
    logic   w_out_free;

    assign o_s_tready = r_s_ready;
    assign w_out_free = !i_status.out_valid || i_m_tready;

    // Decode commands for the datapath
    always_comb begin
        o_cmd.capture = i_s_tvalid && r_s_ready;
        o_cmd.search  = (r_state == S_SEARCH);
        o_cmd.apply   = (r_state == S_APPLY) && w_out_free;
        o_cmd.drain   = i_status.out_valid && i_m_tready;
    end

    // Advance state and hold the input ready flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s_ready <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && r_s_ready) begin
                        r_state   <= S_SEARCH;
                        r_s_ready <= 1'b0;
                    end
                end
                S_SEARCH: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    // Wait until the output register can take the result
                    if (w_out_free) begin
                        r_state   <= S_IDLE;
                        r_s_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state   <= S_IDLE;
                    r_s_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

>>> sv/btb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_datapath
// Fully associative table with 2-bit counters, input latch, tag search
// and output register.
// ----------------------------------------------------------------------------
module btb_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  btb_pkg::t_dp_cmd                    i_cmd,
    input  logic                                i_command,
    input  logic [btb_pkg::IN_DATA_W-1:0]       i_s_tdata,
    output btb_pkg::t_dp_status                 o_status,
    output logic [btb_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    // Input latch
    logic                        r_cmd;
    logic [btb_pkg::ADDR_W-1:0]  r_pc;
    logic                        r_is_branch;
    logic [btb_pkg::ADDR_W-1:0]  r_target_in;
    logic                        r_taken;

    // Table
    logic [btb_pkg::ENTRIES-1:0] r_valid;
    logic [btb_pkg::ADDR_W-1:0]  r_tag     [btb_pkg::ENTRIES];
    logic [btb_pkg::ADDR_W-1:0]  r_target  [btb_pkg::ENTRIES];
    logic [btb_pkg::CTR_W-1:0]   r_counter [btb_pkg::ENTRIES];

    // Search results
    logic [btb_pkg::ENTRIES-1:0] r_hit_vec;
    logic [btb_pkg::ENTRIES-1:0] r_free_vec;
    logic [btb_pkg::ENTRIES-1:0] n_hit_vec;

    // Output register
    logic                        r_out_valid;
    logic                        r_p_taken;
    logic [btb_pkg::ADDR_W-1:0]  r_p_target;
    logic                        r_mis;
    logic [btb_pkg::ADDR_W-1:0]  r_redirect;

    // Apply-stage signals
    logic [btb_pkg::IDX_W-1:0]   w_hit_idx;
    logic [btb_pkg::IDX_W-1:0]   w_free_idx;
    logic                        w_hit;
    logic                        w_free;
    logic [btb_pkg::CTR_W-1:0]   w_ctr;
    logic [btb_pkg::CTR_W-1:0]   w_ctr_next;
    logic                        w_ctr_high;
    logic                        w_insert;
    logic                        w_ctr_wr;
    logic                        n_p_taken;
    logic [btb_pkg::ADDR_W-1:0]  n_p_target;
    logic                        n_mis;
    logic [btb_pkg::ADDR_W-1:0]  n_redirect;

    // Latch the input transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd       <= i_command;
            r_pc        <= i_s_tdata[btb_pkg::ADDR_W-1:0];
            r_is_branch <= i_s_tdata[btb_pkg::ADDR_W];
            r_target_in <= i_s_tdata[2*btb_pkg::ADDR_W:btb_pkg::ADDR_W+1];
            r_taken     <= i_s_tdata[2*btb_pkg::ADDR_W+1];
        end
    end

    // Compare every tag against the latched pc
    always_comb begin
        for (int i = 0; i < btb_pkg::ENTRIES; i++) begin
            n_hit_vec[i] = r_valid[i] && (r_tag[i] == r_pc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_hit_vec  <= n_hit_vec;
            r_free_vec <= ~r_valid;
        end
    end

    // Pick the lowest hit and the lowest free entry
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = btb_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (r_hit_vec[i]) begin
                w_hit_idx = btb_pkg::IDX_W'(i);
            end
            if (r_free_vec[i]) begin
                w_free_idx = btb_pkg::IDX_W'(i);
            end
        end
        w_hit  = |r_hit_vec;
        w_free = |r_free_vec;
    end

    // Form the result and the table update
    always_comb begin
        w_ctr      = r_counter[w_hit_idx];
        w_ctr_high = (w_ctr >= btb_pkg::CTR_TAKEN);
        n_p_taken  = 1'b0;
        n_p_target = '0;
        n_mis      = 1'b0;
        n_redirect = '0;
        w_insert   = 1'b0;
        w_ctr_wr   = 1'b0;
        w_ctr_next = w_ctr;

        if (r_cmd == btb_pkg::CMD_LOOKUP) begin
            if (r_is_branch) begin
                if (!w_hit) begin
                    w_insert = w_free;
                end else if (w_ctr_high) begin
                    n_p_taken  = 1'b1;
                    n_p_target = r_target_in;
                end
            end
        end else begin
            if (w_hit) begin
                w_ctr_wr = 1'b1;
                if (!w_ctr_high && r_taken) begin
                    n_mis      = 1'b1;
                    n_redirect = r_target[w_hit_idx];
                end else if (w_ctr_high && !r_taken) begin
                    n_mis      = 1'b1;
                    n_redirect = r_pc + btb_pkg::ADDR_W'(1);
                end
                // Step the counter toward the outcome, saturating
                if (r_taken) begin
                    if (w_ctr != btb_pkg::CTR_MAX) begin
                        w_ctr_next = w_ctr + btb_pkg::CTR_W'(1);
                    end
                end else begin
                    if (w_ctr != btb_pkg::CTR_MIN) begin
                        w_ctr_next = w_ctr - btb_pkg::CTR_W'(1);
                    end
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.apply && w_insert) begin
            r_valid[w_free_idx] <= 1'b1;
        end
    end

    // Tag, target and counter storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            if (w_insert) begin
                r_tag[w_free_idx]     <= r_pc;
                r_target[w_free_idx]  <= r_target_in;
                r_counter[w_free_idx] <= btb_pkg::CTR_MIN;
            end else if (w_ctr_wr) begin
                r_counter[w_hit_idx]  <= w_ctr_next;
            end
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.drain) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_p_taken  <= n_p_taken;
            r_p_target <= n_p_target;
            r_mis      <= n_mis;
            r_redirect <= n_redirect;
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_m_tdata = {{(btb_pkg::OUT_DATA_W - btb_pkg::OUT_BITS){1'b0}},
                        r_redirect, r_mis, r_p_target, r_p_taken};

endmodule

>>> sv/branch_target_buffer_2bit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_target_buffer_2bit
// Fully associative branch target buffer with 2-bit saturating counters.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | tuser: command;
//           |           |                           | tdata: pc, is_branch,
//           |           |                           | branch_target, taken
//  m_axis   | out       | m_axis_tvalid/tready      | tdata: predict_taken,
//           |           |                           | predicted_target,
//           |           |                           | mispredict, redirect
//
//  Each transaction passes through capture, tag search over all entries,
//  then table update with the result loaded into the output register.
//  Input is taken again in the cycle after the update.
//  A stalled output holds the update stage and keeps the input closed;
//  one more transaction can be captured and searched behind a waiting result.
//  Synchronous active-low reset clears all table valid bits and the output
//  valid flag, and opens the input.
// ----------------------------------------------------------------------------
module branch_target_buffer_2bit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] pc, [32] is_branch, [64:33] branch_target, [65] outcome_taken
    input  logic [btb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] command
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] predict_taken, [32:1] predicted_target, [33] mispredict,
    // [65:34] redirect_address
    output logic [btb_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    btb_pkg::t_dp_cmd    w_cmd;
    btb_pkg::t_dp_status w_status;

    btb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (w_status),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    btb_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_command (s_axis_tuser),
        .i_s_tdata (s_axis_tdata),
        .o_status  (w_status),
        .o_m_tdata (m_axis_tdata)
    );

    assign m_axis_tvalid = w_status.out_valid;

endmodule

>>> sv/btb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_checker
// Port-level checks for the branch target buffer, bound to the top level.
// ----------------------------------------------------------------------------
module btb_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [btb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    // One item in flight: input closes right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // A result never predicts taken and flags a mispredict at once
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[btb_pkg::ADDR_W+1]))
        else $error("result mixes lookup and resolve fields");

    // Addresses are zero when their flag is clear
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[0] || (m_axis_tdata[btb_pkg::ADDR_W:1] == '0)) &&
             (m_axis_tdata[btb_pkg::ADDR_W+1] ||
              (m_axis_tdata[2*btb_pkg::ADDR_W+1:btb_pkg::ADDR_W+2] == '0))))
        else $error("address field set without its flag");

endmodule

bind branch_target_buffer_2bit btb_checker u_btb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
